@@ rtl/dds_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_pkg
// shared constants, command and status codes for the shortest-path engine
// ----------------------------------------------------------------------------
package dds_pkg;

  localparam int NODE_COUNT_DEF    = 64;
  localparam int WEIGHT_BITS_DEF   = 16;
  localparam int DISTANCE_BITS_DEF = 24;

  localparam int OPCODE_BITS = 3;
  localparam int VERTEX_BITS = 6;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 6;

  localparam logic [OPCODE_BITS-1:0] OP_CLEAR    = 3'd0;
  localparam logic [OPCODE_BITS-1:0] OP_ADD_VERT = 3'd1;
  localparam logic [OPCODE_BITS-1:0] OP_ADD_EDGE = 3'd2;
  localparam logic [OPCODE_BITS-1:0] OP_RUN      = 3'd3;
  localparam logic [OPCODE_BITS-1:0] OP_QUERY    = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_UNKNOWN  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_NEGATIVE = 2'd2;

endpackage

@@ rtl/dds_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module dds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/dense_dijkstra_shortest_path.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_dijkstra_shortest_path
// single-source shortest paths over a stored dense weighted digraph
// ----------------------------------------------------------------------------
// usage: one command per input transfer (clear, add vertex, add edge, run,
// query) on the in_valid/in_ready channel; exactly one result per command
// leaves on the out_valid/out_ready channel through an output register.
// the engine handles one command at a time: in_ready is high only while idle.
// add vertex, add edge and a run from an unknown vertex go straight to the
// output step; a query of a known vertex reads the distance memory first.
// clear, and an add edge that is rejected, sweep the whole edge memory first.
// a run alternates a minimum scan and a relax scan over all vertices, once
// per settled vertex, plus one closing minimum scan; each scan reads the
// vertices one by one through the single read port of the distance memory.
// reset: the engine sweeps the whole edge memory, is not ready in that time,
// and emits no result for it.
// a stalled receiver holds the result register; the engine then waits with
// the next result and takes no new command until that transfer completes.
// ----------------------------------------------------------------------------
module dense_dijkstra_shortest_path
  import dds_pkg::*;
#(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF,
  parameter int DISTANCE_BITS = DISTANCE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [OPCODE_BITS-1:0]          opcode,
  input  logic [VERTEX_BITS-1:0]          vertex_a,
  input  logic [VERTEX_BITS-1:0]          vertex_b,
  input  logic signed [WEIGHT_BITS-1:0]   edge_weight,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [STATUS_BITS-1:0]          status,
  output logic [DISTANCE_BITS-1:0]        path_length,
  output logic                            reachable,
  output logic [COUNT_BITS-1:0]           update_count
);

  localparam int VB    = $clog2(NODE_COUNT);
  localparam int EDGES = NODE_COUNT * NODE_COUNT;
  localparam int EA    = $clog2(EDGES);
  localparam int EW    = WEIGHT_BITS + 1;
  localparam int DW    = DISTANCE_BITS + COUNT_BITS;
  localparam int SW    = (DISTANCE_BITS > WEIGHT_BITS ? DISTANCE_BITS : WEIGHT_BITS) + 1;

  typedef enum logic [2:0] {
    S_SWEEP, S_IDLE, S_QUERY, S_SELECT, S_RELAX, S_DONE
  } state_t;

  state_t                   state;
  logic [EA:0]              sweep;
  logic                     res_pend;
  logic [VB:0]              cnt;
  logic                     rd_pend;
  logic [VB-1:0]            rd_idx;
  logic                     best_found;
  logic [DISTANCE_BITS-1:0] best_dist;
  logic [VB-1:0]            pick;
  logic [NODE_COUNT-1:0]    present;
  logic [NODE_COUNT-1:0]    known;
  logic [NODE_COUNT-1:0]    settled;
  logic [STATUS_BITS-1:0]   res_status;
  logic [DISTANCE_BITS-1:0] res_len;
  logic                     res_reach;
  logic [COUNT_BITS-1:0]    res_cnt;

  // memory ports
  logic              e_we;
  logic [EA-1:0]     e_waddr, e_raddr;
  logic [EW-1:0]     e_wdata, e_rdata;
  logic              d_we;
  logic [VB-1:0]     d_waddr, d_raddr;
  logic [DW-1:0]     d_wdata, d_rdata;

  // command decode
  logic          in_fire;
  logic [VB-1:0] a_idx, b_idx;
  logic          a_ok, b_ok, a_known, b_known, negative;
  logic [EA-1:0] edge_addr_in;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign a_idx    = VB'(vertex_a);
  assign b_idx    = VB'(vertex_b);
  assign a_ok     = 32'(vertex_a) < NODE_COUNT;
  assign b_ok     = 32'(vertex_b) < NODE_COUNT;
  assign a_known  = a_ok && present[a_idx];
  assign b_known  = b_ok && present[b_idx];
  assign negative = edge_weight[WEIGHT_BITS-1];
  assign edge_addr_in = EA'(a_idx) * EA'(NODE_COUNT) + EA'(b_idx);

  // relax datapath: the one shared add / saturate / compare unit
  logic [VB-1:0]            n_idx;
  logic                     ev_valid;
  logic [WEIGHT_BITS-1:0]   ev_weight;
  logic [DISTANCE_BITS-1:0] old_dist;
  logic [COUNT_BITS-1:0]    old_cnt, new_cnt;
  logic [SW-1:0]            sum;
  logic [DISTANCE_BITS-1:0] cand;
  logic                     relax_hit;
  logic                     sel_elig;

  assign n_idx     = rd_idx;
  assign ev_valid  = e_rdata[EW-1];
  assign ev_weight = e_rdata[WEIGHT_BITS-1:0];
  assign old_dist  = d_rdata[DISTANCE_BITS-1:0];
  assign old_cnt   = d_rdata[DW-1:DISTANCE_BITS];
  assign sum       = SW'(best_dist) + SW'(ev_weight);
  assign cand      = (sum > SW'({DISTANCE_BITS{1'b1}})) ? {DISTANCE_BITS{1'b1}}
                                                         : sum[DISTANCE_BITS-1:0];
  assign relax_hit = rd_pend && ev_valid && present[n_idx] && !settled[n_idx]
                     && (!known[n_idx] || cand < old_dist);
  assign new_cnt   = !known[n_idx] ? COUNT_BITS'(1)
                   : (&old_cnt) ? old_cnt : old_cnt + COUNT_BITS'(1);
  assign sel_elig  = present[rd_idx] && !settled[rd_idx] && known[rd_idx];

  // memory port steering
  always_comb begin
    e_we    = 1'b0;
    e_waddr = sweep[EA-1:0];
    e_wdata = '0;
    e_raddr = EA'(pick) * EA'(NODE_COUNT) + EA'(cnt[VB-1:0]);
    d_we    = 1'b0;
    d_waddr = n_idx;
    d_wdata = {new_cnt, cand};
    d_raddr = cnt[VB-1:0];
    case (state)
      S_SWEEP: begin
        e_we = 1'b1;
      end
      S_IDLE: begin
        d_raddr = a_idx;
        if (in_fire && opcode == OP_ADD_EDGE && !negative && a_known && b_known) begin
          e_we    = 1'b1;
          e_waddr = edge_addr_in;
          e_wdata = {1'b1, (a_idx == b_idx) ? WEIGHT_BITS'(0) : WEIGHT_BITS'(edge_weight)};
        end
        if (in_fire && opcode == OP_RUN && a_known) begin
          // start vertex at distance 0 with no updates
          d_we    = 1'b1;
          d_waddr = a_idx;
          d_wdata = '0;
        end
      end
      S_RELAX: begin
        d_we = relax_hit;
      end
      default: begin
      end
    endcase
  end

  dds_ram #(.WIDTH(EW), .DEPTH(EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  dds_ram #(.WIDTH(DW), .DEPTH(NODE_COUNT)) u_dist_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep      <= '0;
      res_pend   <= 1'b0;
      cnt        <= '0;
      rd_pend    <= 1'b0;
      best_found <= 1'b0;
      present    <= '0;
      known      <= '0;
      settled    <= '0;
      out_valid  <= 1'b0;
    end else begin
      // result register empties on its transfer unless refilled below
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          if (sweep == (EA+1)'(EDGES - 1)) begin
            state <= res_pend ? S_DONE : S_IDLE;
          end
          sweep <= sweep + 1'b1;
        end
        S_IDLE: begin
          if (in_fire) begin
            res_len    <= '0;
            res_reach  <= 1'b0;
            res_cnt    <= '0;
            pick       <= a_idx;
            case (opcode)
              OP_CLEAR: begin
                res_status <= ST_OK;
                present    <= '0;
                known      <= '0;
                settled    <= '0;
                sweep      <= '0;
                res_pend   <= 1'b1;
                state      <= S_SWEEP;
              end
              OP_ADD_VERT: begin
                res_status <= a_ok ? ST_OK : ST_UNKNOWN;
                state      <= S_DONE;
                if (a_ok && !present[a_idx]) begin
                  present[a_idx] <= 1'b1;
                  known[a_idx]   <= 1'b0;
                  settled[a_idx] <= 1'b0;
                end
              end
              OP_ADD_EDGE: begin
                if (negative || !a_known || !b_known) begin
                  // rejected edge wipes the graph
                  res_status <= negative ? ST_NEGATIVE : ST_UNKNOWN;
                  present    <= '0;
                  known      <= '0;
                  settled    <= '0;
                  sweep      <= '0;
                  res_pend   <= 1'b1;
                  state      <= S_SWEEP;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_DONE;
                end
              end
              OP_RUN: begin
                if (!a_known) begin
                  res_status <= ST_UNKNOWN;
                  state      <= S_DONE;
                end else begin
                  // only the start vertex has a finite distance
                  res_status <= ST_OK;
                  known      <= NODE_COUNT'(1) << a_idx;
                  settled    <= '0;
                  cnt        <= '0;
                  rd_pend    <= 1'b0;
                  best_found <= 1'b0;
                  state      <= S_SELECT;
                end
              end
              OP_QUERY: begin
                if (!a_known) begin
                  res_status <= ST_UNKNOWN;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_QUERY;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_QUERY: begin
          // distance word for pick is on the read port now
          if (known[pick]) begin
            res_len   <= old_dist;
            res_reach <= 1'b1;
            res_cnt   <= old_cnt;
          end
          state <= S_DONE;
        end
        S_SELECT: begin
          // minimum scan, ties to the lowest index
          if (cnt != (VB+1)'(NODE_COUNT)) begin
            rd_pend <= 1'b1;
            rd_idx  <= cnt[VB-1:0];
            cnt     <= cnt + 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend && sel_elig && (!best_found || old_dist < best_dist)) begin
            best_found <= 1'b1;
            best_dist  <= old_dist;
            pick       <= rd_idx;
          end
          if (cnt == (VB+1)'(NODE_COUNT) && !rd_pend) begin
            cnt <= '0;
            if (best_found) begin
              settled[pick] <= 1'b1;
              state         <= S_RELAX;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_RELAX: begin
          // relax the out-edges of pick, one neighbour a cycle
          if (cnt != (VB+1)'(NODE_COUNT)) begin
            rd_pend <= 1'b1;
            rd_idx  <= cnt[VB-1:0];
            cnt     <= cnt + 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (relax_hit) begin
            known[n_idx] <= 1'b1;
          end
          if (cnt == (VB+1)'(NODE_COUNT) && !rd_pend) begin
            cnt        <= '0;
            best_found <= 1'b0;
            state      <= S_SELECT;
          end
        end
        S_DONE: begin
          res_pend <= 1'b0;
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            path_length  <= res_len;
            reachable    <= res_reach;
            update_count <= res_cnt;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/sv/dds_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_checker
// watches both channels, predicts every shortest-path result and compares it
// ----------------------------------------------------------------------------
module dds_checker
  import dds_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [OPCODE_BITS-1:0]       opcode,
  input  logic [VERTEX_BITS-1:0]       vertex_a,
  input  logic [VERTEX_BITS-1:0]       vertex_b,
  input  logic signed [WEIGHT_BITS_DEF-1:0] edge_weight,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [STATUS_BITS-1:0]       status,
  input  logic [DISTANCE_BITS_DEF-1:0] path_length,
  input  logic                         reachable,
  input  logic [COUNT_BITS-1:0]        update_count,
  output int                           error_count,
  output int                           outstanding,
  output int                           checked
);

  localparam int NV = NODE_COUNT_DEF;
  localparam longint DIST_SAT = (64'd1 << DISTANCE_BITS_DEF) - 1;

  typedef struct packed {
    logic [STATUS_BITS-1:0]       st;
    logic [DISTANCE_BITS_DEF-1:0] len;
    logic                         reach;
    logic [COUNT_BITS-1:0]        cnt;
  } answer_t;

  answer_t answers_due[$];

  bit     edge_set[NV][NV];
  longint edge_wt[NV][NV];
  bit     present[NV];
  longint dist_val[NV];
  bit     dist_known[NV];
  bit     settled_v[NV];
  int     improved[NV];

  function automatic void wipe_graph_state();
    for (int i = 0; i < NV; i++) begin
      for (int j = 0; j < NV; j++) begin
        edge_set[i][j] = 0;
        edge_wt[i][j]  = 0;
      end
      present[i] = 0;
      dist_val[i] = 0;
      dist_known[i] = 0;
      settled_v[i] = 0;
      improved[i] = 0;
    end
  endfunction

  function automatic bit vertex_known(int v);
    return v < NV && present[v];
  endfunction

  function automatic void shortest_paths_from(int src);
    int pick;
    longint cand;
    for (int i = 0; i < NV; i++) begin
      dist_val[i] = 0;
      dist_known[i] = 0;
      settled_v[i] = 0;
      improved[i] = 0;
    end
    dist_known[src] = 1;
    forever begin
      pick = -1;
      for (int i = 0; i < NV; i++)
        if (present[i] && !settled_v[i] && dist_known[i])
          if (pick < 0 || dist_val[i] < dist_val[pick]) pick = i;
      if (pick < 0) break;
      settled_v[pick] = 1;
      for (int n = 0; n < NV; n++) begin
        if (!edge_set[pick][n] || !present[n] || settled_v[n]) continue;
        cand = dist_val[pick] + edge_wt[pick][n];
        if (cand > DIST_SAT) cand = DIST_SAT;
        if (!dist_known[n] || cand < dist_val[n]) begin
          dist_val[n] = cand;
          dist_known[n] = 1;
          if (improved[n] < 63) improved[n]++;
        end
      end
    end
  endfunction

  function automatic answer_t apply_command(logic [OPCODE_BITS-1:0] op, int a, int b,
                                            logic signed [WEIGHT_BITS_DEF-1:0] w);
    answer_t r;
    r = '0;
    r.st = ST_OK;
    case (op)
      OP_CLEAR: wipe_graph_state();
      OP_ADD_VERT: begin
        if (a >= NV) r.st = ST_UNKNOWN;
        else if (!present[a]) begin
          present[a] = 1;
          dist_val[a] = 0;
          dist_known[a] = 0;
          settled_v[a] = 0;
          improved[a] = 0;
        end
      end
      OP_ADD_EDGE: begin
        if (w < 0) begin
          wipe_graph_state();
          r.st = ST_NEGATIVE;
        end else if (!vertex_known(a) || !vertex_known(b)) begin
          wipe_graph_state();
          r.st = ST_UNKNOWN;
        end else begin
          edge_set[a][b] = 1;
          edge_wt[a][b] = (a == b) ? 0 : longint'(w);
        end
      end
      OP_RUN: begin
        if (!vertex_known(a)) r.st = ST_UNKNOWN;
        else shortest_paths_from(a);
      end
      OP_QUERY: begin
        if (!vertex_known(a)) r.st = ST_UNKNOWN;
        else if (dist_known[a]) begin
          r.len   = dist_val[a][DISTANCE_BITS_DEF-1:0];
          r.reach = 1'b1;
          r.cnt   = improved[a][COUNT_BITS-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    error_count = 0;
    checked = 0;
    wipe_graph_state();
  end

  assign outstanding = answers_due.size();

  always @(posedge clk) begin
    answer_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        answers_due.push_back(apply_command(opcode, vertex_a, vertex_b, edge_weight));
      if (out_valid && out_ready) begin
        checked++;
        if (answers_due.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result status=%0d len=%0d reach=%0d cnt=%0d",
                   $time, status, path_length, reachable, update_count);
        end else begin
          want = answers_due.pop_front();
          if (status !== want.st) begin
            error_count++;
            $display("%0t: status expected %0d got %0d", $time, want.st, status);
          end
          if (path_length !== want.len) begin
            error_count++;
            $display("%0t: path_length expected %0d got %0d", $time, want.len, path_length);
          end
          if (reachable !== want.reach) begin
            error_count++;
            $display("%0t: reachable expected %0d got %0d", $time, want.reach, reachable);
          end
          if (update_count !== want.cnt) begin
            error_count++;
            $display("%0t: update_count expected %0d got %0d", $time, want.cnt,
                     update_count);
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// graph-building command streams under varied idling, checked by dds_checker
// ----------------------------------------------------------------------------
module tb_top;
  import dds_pkg::*;

  // opcodes the engine ignores
  localparam logic [OPCODE_BITS-1:0] OP_RESERVED_FIRST = 3'd5;
  localparam logic [OPCODE_BITS-1:0] OP_RESERVED_LAST  = 3'd7;
  // longest quiet stretch, long enough for a full 64-vertex run
  localparam int QUIET_LIMIT = 60000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OPCODE_BITS-1:0] opcode = '0;
  logic [VERTEX_BITS-1:0] vertex_a = '0;
  logic [VERTEX_BITS-1:0] vertex_b = '0;
  logic signed [WEIGHT_BITS_DEF-1:0] edge_weight = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_BITS-1:0] status;
  logic [DISTANCE_BITS_DEF-1:0] path_length;
  logic reachable;
  logic [COUNT_BITS-1:0] update_count;

  int error_count, outstanding, checked;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit hold_req = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  dense_dijkstra_shortest_path u_top (
    .clk, .rst, .in_valid, .in_ready, .opcode, .vertex_a, .vertex_b, .edge_weight,
    .out_valid, .out_ready, .status, .path_length, .reachable, .update_count
  );

  dds_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .opcode, .vertex_a, .vertex_b, .edge_weight,
    .out_valid, .out_ready, .status, .path_length, .reachable, .update_count,
    .error_count, .outstanding, .checked
  );

  // receiver: random stalls, or a long hold-off when asked for one
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end
      out_ready = ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QUIET_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one command transfer; entered and left at a falling edge
  task automatic send_cmd(input logic [OPCODE_BITS-1:0] op, input int a, input int b,
                          input int w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    opcode = op;
    vertex_a = a[VERTEX_BITS-1:0];
    vertex_b = b[VERTEX_BITS-1:0];
    edge_weight = w[WEIGHT_BITS_DEF-1:0];
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic int pick_weight();
    if ($urandom_range(9) == 0) return $urandom_range(32767);
    return $urandom_range(40);
  endfunction

  // build a graph, run from one of its vertices and query it all
  task automatic graph_episode(input int nv, input int ne, input bit noisy);
    int verts[$];
    int v, s, d;
    send_cmd(OP_CLEAR, $urandom_range(63), $urandom_range(63), $urandom);
    while (verts.size() < nv) begin
      v = $urandom_range(63);
      if (!(v inside {verts})) verts.push_back(v);
    end
    foreach (verts[i]) send_cmd(OP_ADD_VERT, verts[i], $urandom_range(63), $urandom);
    for (int e = 0; e < ne; e++) begin
      s = verts[$urandom_range(nv - 1)];
      d = verts[$urandom_range(nv - 1)];
      send_cmd(OP_ADD_EDGE, s, d, pick_weight());
      if (noisy && $urandom_range(19) == 0)
        send_cmd(OPCODE_BITS'($urandom_range(OP_RESERVED_LAST)), $urandom_range(63),
                 $urandom_range(63), $urandom);
    end
    if ($urandom_range(3) == 0)
      send_cmd(OP_QUERY, verts[$urandom_range(nv - 1)], 0, 0);
    send_cmd(OP_RUN, verts[$urandom_range(nv - 1)], $urandom_range(63), $urandom);
    // late vertex: present but untouched by the run
    if ($urandom_range(3) == 0) send_cmd(OP_ADD_VERT, $urandom_range(63), 0, 0);
    foreach (verts[i]) send_cmd(OP_QUERY, verts[i], $urandom_range(63), $urandom);
    send_cmd(OP_QUERY, $urandom_range(63), 0, 0);
    if (noisy) begin
      send_cmd(OP_RUN, $urandom_range(63), 0, 0);
      send_cmd(OP_QUERY, verts[$urandom_range(nv - 1)], 0, 0);
      send_cmd(OPCODE_BITS'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST)),
               $urandom_range(63), $urandom_range(63), $urandom);
      // broken edges: negative weight or unknown endpoint wipe the graph
      send_cmd(OP_ADD_EDGE, $urandom_range(63), $urandom_range(63), $urandom);
      send_cmd(OP_QUERY, verts[0], 0, 0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed corners
    send_cmd(OP_QUERY, 0, 0, 0);
    send_cmd(OP_ADD_VERT, 0, 0, 0);
    send_cmd(OP_ADD_VERT, 63, 63, 0);
    send_cmd(OP_ADD_VERT, 0, 0, 0);
    send_cmd(OP_ADD_EDGE, 0, 63, 32767);
    send_cmd(OP_ADD_EDGE, 63, 63, 5);
    send_cmd(OP_QUERY, 63, 0, 0);
    send_cmd(OP_RUN, 0, 0, 0);
    send_cmd(OP_QUERY, 63, 0, 0);
    send_cmd(OP_ADD_EDGE, 0, 63, 0);
    send_cmd(OP_RUN, 0, 0, 0);
    send_cmd(OP_QUERY, 63, 0, 0);
    send_cmd(OP_QUERY, 0, 0, 0);
    send_cmd(OP_ADD_EDGE, 0, 5, 1);
    send_cmd(OP_QUERY, 0, 0, 0);
    send_cmd(OP_ADD_VERT, 1, 0, 0);
    send_cmd(OP_ADD_VERT, 2, 0, 0);
    send_cmd(OP_ADD_EDGE, 1, 2, -32768);
    send_cmd(OP_QUERY, 1, 0, 0);
    send_cmd(OP_RUN, 1, 0, 0);
    send_cmd(OP_RESERVED_LAST, 63, 63, -1);
    send_cmd(OP_RESERVED_FIRST, 0, 0, 0);
    send_cmd(OP_CLEAR, 0, 0, 0);
    send_cmd(OP_QUERY, 63, 63, 32767);
    wait_drained();

    // random graphs, one idling pattern per phase
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
        default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
      endcase
      if (ph == 0) graph_episode(64, 250, 0);
      for (int ep = 0; ep < 9; ep++) begin
        if (ph == 2 && ep == 4) hold_req = 1;
        graph_episode($urandom_range(2, 10), $urandom_range(3, 24), $urandom_range(2) == 0);
        if (ep == 5) wait_drained();
      end
      wait_drained();
    end

    wait_drained();
    repeat (50) @(negedge clk);
    $display("covered %0d commands and %0d checked results over four idling patterns",
             items_sent, checked);
    if (error_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
